[hdl/smaema_pkg.sv]
// Shared types, constants and a helper function of the moving average tracker.
`timescale 1ns / 1ps

package smaema_pkg;

    localparam int SAMPLE_W = 24;
    localparam int PERIOD_W = 6;
    localparam int SUM_W    = 30;
    localparam int CFG_IDX_W = 1;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 6'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 6'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 6'd5;
    localparam logic [PERIOD_W-1:0] COUNT_MAX    = 6'd50;

    localparam logic [CFG_IDX_W-1:0] REG_SMA_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EMA_PERIOD = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } sample_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sma_value;
        logic signed [SAMPLE_W-1:0] ema_value;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] v);
        logic [PERIOD_W-1:0] r;
        if (v < PERIOD_MIN)
        begin
            r = PERIOD_MIN;
        end
        else if (v > PERIOD_MAX)
        begin
            r = PERIOD_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hdl/smaema_div.sv]
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module smaema_div #(
    parameter int W = 30
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [W-1:0]                     dividend,
    input  logic [smaema_pkg::PERIOD_W-1:0]         divisor,
    output logic                                    done,
    output logic signed [W-1:0]                     quotient
);

    localparam int CNT_W = $clog2(W + 1);
    localparam int DW    = smaema_pkg::PERIOD_W;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     acc_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    div_reg;
    logic             neg_reg;

    logic [DW:0]      trial;
    logic             qbit;
    logic [DW-1:0]    rem_new;
    logic [DW:0]      diff;

    assign trial   = {rem_reg, acc_reg[W-1]};
    assign diff    = trial - {1'b0, div_reg};
    assign qbit    = (trial >= {1'b0, div_reg});
    assign rem_new = qbit ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[W-1];
            acc_reg <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[W-2:0], qbit};
            rem_reg <= rem_new;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~acc_reg + 1'b1) : acc_reg;

endmodule

[hdl/smaema_ring.sv]
// Sample window ring: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module smaema_ring #(
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [$clog2(DEPTH)-1:0]                 waddr,
    input  logic signed [smaema_pkg::SAMPLE_W-1:0]   wdata,
    input  logic                                     re,
    input  logic [$clog2(DEPTH)-1:0]                 raddr,
    output logic signed [smaema_pkg::SAMPLE_W-1:0]   rdata
);

    logic signed [smaema_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic signed [smaema_pkg::SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/sma_ema_tracker_unit.sv]
// Top level of the simple and exponential moving average tracker.
`timescale 1ns / 1ps

// Each accepted request on the input channel carries one Q15.8 sample and a
// restart flag, and produces exactly one result on the output channel with the
// simple and the exponential moving average. The block works on one request at
// a time: in_ready is high only while it is idle. After a sample is written to
// the window memory, the previous sma_period - 1 samples are read back one per
// cycle through the memory read port and summed, and the sum then goes through
// a serial divider. The exponential update runs in a second serial divider in
// parallel, and the next request can be taken in the same cycle that the result
// appears. The first sample of a series needs no division. During warm-up the
// window is not read and only the exponential divider sets the time. Reset
// clears all control state and sets both periods to 5; the window memory needs
// no clearing pass. The result waits in an output register while the receiver
// stalls, and the block stays busy until that register is free. Configuration
// writes are taken at any edge with cfg_we high.
module sma_ema_tracker_unit #(
    parameter int WINDOW_DEPTH  = 64,
    parameter int EMA_FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  smaema_pkg::sample_in_t                in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output smaema_pkg::result_t                   out_data,
    input  logic                                  cfg_we,
    input  logic [smaema_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smaema_pkg::PERIOD_W-1:0]       cfg_data
);

    localparam int AW     = $clog2(WINDOW_DEPTH);
    localparam int SW     = smaema_pkg::SAMPLE_W;
    localparam int PW     = smaema_pkg::PERIOD_W;
    localparam int SUMW   = smaema_pkg::SUM_W;
    localparam int ACC_W  = SW + EMA_FRAC_BITS;
    localparam int EDIV_W = ACC_W + 2;

    smaema_pkg::state_t state_reg;

    logic [PW-1:0]          sma_period_reg;
    logic [PW-1:0]          ema_period_reg;
    logic [AW-1:0]          ws_reg;
    logic [PW-1:0]          seen_reg;
    logic                   seeded_reg;
    logic signed [ACC_W-1:0] accum_reg;
    logic [PW-1:0]          reads_left_reg;
    logic                   rvalid_reg;
    logic                   ema_upd_reg;
    logic                   use_sma_reg;
    logic                   sma_pend_reg;
    logic                   ema_pend_reg;
    logic                   out_valid_reg;

    logic [AW-1:0]          rd_ptr_reg;
    logic signed [SW-1:0]   x_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [SW-1:0]   sma_res_reg;
    smaema_pkg::result_t    out_data_reg;

    logic                   accept;
    logic [PW-1:0]          seen_eff;
    logic                   seeded_eff;
    logic                   use_sma;
    logic signed [ACC_W:0]  x_scaled;
    logic signed [ACC_W:0]  delta;
    logic signed [EDIV_W-1:0] ema_dividend;
    logic                   ema_start;
    logic                   sma_start;
    logic                   rd_en;
    logic [AW-1:0]          ws_prev;
    logic [AW-1:0]          ws_inc;
    logic [AW-1:0]          rd_ptr_dec;
    logic signed [SW-1:0]   rdata;
    logic                   sma_done;
    logic                   ema_done;
    logic signed [SUMW-1:0] sma_quot;
    logic signed [EDIV_W-1:0] ema_quot;
    logic                   div_finished;
    logic                   out_free;
    logic signed [ACC_W-1:0] accum_new;
    logic [PW-1:0]          ema_divisor;

    assign in_ready   = (state_reg == smaema_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign seen_eff   = in_data.restart ? '0 : seen_reg;
    assign seeded_eff = !in_data.restart && seeded_reg;
    assign use_sma    = (seen_eff >= sma_period_reg);

    assign x_scaled     = {in_data.sample[SW-1], in_data.sample, {EMA_FRAC_BITS{1'b0}}};
    assign delta        = x_scaled - {accum_reg[ACC_W-1], accum_reg};
    assign ema_dividend = {delta, 1'b0};
    assign ema_start    = accept && seeded_eff;
    assign ema_divisor  = ema_period_reg + 1'b1;

    assign rd_en     = (state_reg == smaema_pkg::ST_SUM) && (reads_left_reg != '0);
    assign sma_start = (state_reg == smaema_pkg::ST_SUM) && (reads_left_reg == '0)
                       && !rvalid_reg;

    assign ws_prev    = (ws_reg == '0) ? AW'(WINDOW_DEPTH - 1) : ws_reg - 1'b1;
    assign ws_inc     = (ws_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : ws_reg + 1'b1;
    assign rd_ptr_dec = (rd_ptr_reg == '0) ? AW'(WINDOW_DEPTH - 1) : rd_ptr_reg - 1'b1;

    assign div_finished = (state_reg == smaema_pkg::ST_DIV) && !sma_pend_reg
                          && !ema_pend_reg;
    assign out_free     = !out_valid_reg || out_ready;
    assign accum_new    = ema_upd_reg ? (accum_reg + ema_quot[ACC_W-1:0])
                                      : {x_reg, {EMA_FRAC_BITS{1'b0}}};

    smaema_ring #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (ws_reg),
        .wdata (in_data.sample),
        .re    (rd_en),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    smaema_div #(
        .W (SUMW)
    ) u_sma_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sma_start),
        .dividend (sum_reg),
        .divisor  (sma_period_reg),
        .done     (sma_done),
        .quotient (sma_quot)
    );

    smaema_div #(
        .W (EDIV_W)
    ) u_ema_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ema_start),
        .dividend (ema_dividend),
        .divisor  (ema_divisor),
        .done     (ema_done),
        .quotient (ema_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sma_period_reg <= smaema_pkg::PERIOD_RESET;
            ema_period_reg <= smaema_pkg::PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smaema_pkg::REG_SMA_PERIOD: sma_period_reg <= smaema_pkg::clamp_period(cfg_data);
                smaema_pkg::REG_EMA_PERIOD: ema_period_reg <= smaema_pkg::clamp_period(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= smaema_pkg::ST_IDLE;
            ws_reg         <= '0;
            seen_reg       <= '0;
            seeded_reg     <= 1'b0;
            accum_reg      <= '0;
            reads_left_reg <= '0;
            rvalid_reg     <= 1'b0;
            ema_upd_reg    <= 1'b0;
            use_sma_reg    <= 1'b0;
            sma_pend_reg   <= 1'b0;
            ema_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (sma_done)
            begin
                sma_pend_reg <= 1'b0;
            end
            if (ema_done)
            begin
                ema_pend_reg <= 1'b0;
            end
            if (out_valid_reg && out_ready && (state_reg != smaema_pkg::ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                smaema_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        ema_upd_reg    <= seeded_eff;
                        ema_pend_reg   <= seeded_eff;
                        use_sma_reg    <= use_sma;
                        seeded_reg     <= 1'b1;
                        seen_reg       <= (seen_eff < smaema_pkg::COUNT_MAX) ?
                                          seen_eff + 1'b1 : seen_eff;
                        ws_reg         <= ws_inc;
                        reads_left_reg <= sma_period_reg - 1'b1;
                        rvalid_reg     <= 1'b0;
                        state_reg      <= use_sma ? smaema_pkg::ST_SUM : smaema_pkg::ST_DIV;
                    end
                end
                smaema_pkg::ST_SUM:
                begin
                    rvalid_reg <= rd_en;
                    if (rd_en)
                    begin
                        reads_left_reg <= reads_left_reg - 1'b1;
                    end
                    if (sma_start)
                    begin
                        sma_pend_reg <= 1'b1;
                        state_reg    <= smaema_pkg::ST_DIV;
                    end
                end
                smaema_pkg::ST_DIV:
                begin
                    if (div_finished)
                    begin
                        accum_reg <= accum_new;
                        state_reg <= smaema_pkg::ST_OUT;
                    end
                end
                smaema_pkg::ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= smaema_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= smaema_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg      <= in_data.sample;
            rd_ptr_reg <= ws_prev;
            sum_reg    <= SUMW'(in_data.sample);
        end
        else if (state_reg == smaema_pkg::ST_SUM)
        begin
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_dec;
            end
            if (rvalid_reg)
            begin
                sum_reg <= sum_reg + SUMW'(rdata);
            end
        end
        if (div_finished)
        begin
            sma_res_reg <= use_sma_reg ? sma_quot[SW-1:0] : x_reg;
        end
        if ((state_reg == smaema_pkg::ST_OUT) && out_free)
        begin
            out_data_reg.sma_value <= sma_res_reg;
            out_data_reg.ema_value <= accum_reg[ACC_W-1 -: SW];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[hdl/smaema_checker.sv]
// Port-level checker for the moving average tracker and its bind statement.
`timescale 1ns / 1ps

module smaema_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input smaema_pkg::result_t out_data
);

    // A stalled result keeps its value until the receiver takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // Only one request is in flight, so the block is busy right after accepting one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while a previous one is in flight");

    // The block only becomes ready again when it hands over a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("block became ready without presenting a result");

endmodule

bind sma_ema_tracker_unit smaema_checker u_smaema_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
